>>> sv/coc_pkg.sv
// ----------------------------------------------------------------------------
// coc_pkg
// Shared widths, codes and types of the current offset calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package coc_pkg;

   localparam int DATA_W = 12;

   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [DATA_W-1:0] SPREAD_LIMIT_RESET = 12'd16;

   typedef struct packed {
      logic clr;
      logic upd;
   } lane_cmd_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } pipe_en_type;

   typedef struct packed {
      logic axis;
      logic aborted;
   } tag_type;

   typedef struct packed {
      logic              axis_out;
      logic [DATA_W-1:0] offset_a;
      logic [DATA_W-1:0] offset_b;
      logic [DATA_W-1:0] spread;
      logic              offset_ok;
      logic              aborted;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> sv/coc_ifs.sv
// ----------------------------------------------------------------------------
// coc channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface coc_req_if import coc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic              axis;
   logic              outputs_enabled;
   logic [DATA_W-1:0] sample_a;
   logic [DATA_W-1:0] sample_b;

   modport source (
      output valid, func, axis, outputs_enabled, sample_a, sample_b,
      input  ready
   );
   modport sink (
      input  valid, func, axis, outputs_enabled, sample_a, sample_b,
      output ready
   );
endinterface

interface coc_rsp_if import coc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              axis_out;
   logic [DATA_W-1:0] offset_a;
   logic [DATA_W-1:0] offset_b;
   logic [DATA_W-1:0] spread;
   logic              offset_ok;
   logic              aborted;

   modport source (
      output valid, axis_out, offset_a, offset_b, spread, offset_ok, aborted,
      input  ready
   );
   modport sink (
      input  valid, axis_out, offset_a, offset_b, spread, offset_ok, aborted,
      output ready
   );
endinterface

interface coc_csr_if import coc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/coc_lane.sv
// ----------------------------------------------------------------------------
// coc_lane
// One ADC channel: per-axis sum and min/max trackers, then a three-stage
// mean computation by reciprocal multiply with a one-step correction.
// ----------------------------------------------------------------------------
`default_nettype none

module coc_lane import coc_pkg::*; #(
   parameter int ADC_BITS       = 12,
   parameter int AXES           = 2,
   parameter int OFFSET_SAMPLES = 64,
   parameter int AX_W           = 1
) (
   input  wire logic                clock,
   input  wire lane_cmd_type        cmd,
   input  wire logic [AX_W-1:0]     idx,
   input  wire logic [ADC_BITS-1:0] sample,
   input  wire pipe_en_type         en,
   output logic      [ADC_BITS-1:0] mean,
   output logic      [ADC_BITS-1:0] spread
);

   localparam int SUM_W  = ADC_BITS + $clog2(OFFSET_SAMPLES);
   localparam int PROD_W = 2 * SUM_W;
   localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / OFFSET_SAMPLES);
   localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(OFFSET_SAMPLES);
   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;

   logic [SUM_W-1:0]    sum_ff [AXES];
   logic [ADC_BITS-1:0] min_ff [AXES];
   logic [ADC_BITS-1:0] max_ff [AXES];

   logic [SUM_W-1:0]    sum_in;
   logic [ADC_BITS-1:0] min_in;
   logic [ADC_BITS-1:0] max_in;

   logic [SUM_W-1:0]    s1_sum_ff;
   logic [ADC_BITS-1:0] s1_min_ff;
   logic [ADC_BITS-1:0] s1_max_ff;

   logic [SUM_W-1:0]    s2_sum_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic [PROD_W-1:0]   s2_prod_in;
   logic [ADC_BITS-1:0] s2_spread_ff;
   logic [ADC_BITS-1:0] s2_spread_in;

   logic [SUM_W-1:0]    s3_sum_ff;
   logic [ADC_BITS-1:0] s3_q0_ff;
   logic [ADC_BITS-1:0] s3_q0_in;
   logic [SUM_W-1:0]    s3_qn_ff;
   logic [SUM_W-1:0]    s3_qn_in;
   logic [ADC_BITS-1:0] s3_spread_ff;
   logic [SUM_W-1:0]    rem;

   // accumulate and track
   always_comb begin
      if (cmd.clr) begin
         sum_in = '0;
         min_in = FULL_SCALE;
         max_in = '0;
      end else begin
         sum_in = sum_ff[idx] + SUM_W'(sample);
         min_in = (sample < min_ff[idx]) ? sample : min_ff[idx];
         max_in = (sample > max_ff[idx]) ? sample : max_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr || cmd.upd) begin
         sum_ff[idx] <= sum_in;
         min_ff[idx] <= min_in;
         max_ff[idx] <= max_in;
      end
   end

   // mean pipeline
   assign s2_prod_in   = s1_sum_ff * RECIP;
   assign s2_spread_in = (s1_max_ff >= s1_min_ff) ? (s1_max_ff - s1_min_ff) : '0;
   assign s3_q0_in     = ADC_BITS'(s2_prod_ff >> SUM_W);
   assign s3_qn_in     = SUM_W'(s3_q0_in) * DIVISOR;

   always_ff @(posedge clock) begin
      if (en.ld1) begin
         s1_sum_ff <= sum_in;
         s1_min_ff <= min_in;
         s1_max_ff <= max_in;
      end
      if (en.ld2) begin
         s2_sum_ff    <= s1_sum_ff;
         s2_prod_ff   <= s2_prod_in;
         s2_spread_ff <= s2_spread_in;
      end
      if (en.ld3) begin
         s3_sum_ff    <= s2_sum_ff;
         s3_q0_ff     <= s3_q0_in;
         s3_qn_ff     <= s3_qn_in;
         s3_spread_ff <= s2_spread_ff;
      end
   end

   // quotient estimate is low by at most one
   assign rem    = s3_sum_ff - s3_qn_ff;
   assign mean   = (rem >= DIVISOR) ? (s3_q0_ff + ADC_BITS'(1)) : s3_q0_ff;
   assign spread = s3_spread_ff;

endmodule

`default_nettype wire

>>> sv/coc_merge.sv
// ----------------------------------------------------------------------------
// coc_merge
// Combines both lanes into one response word: larger spread, limit check,
// refused-start word, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module coc_merge import coc_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire tag_type             tag,
   input  wire logic [ADC_BITS-1:0] mean_a,
   input  wire logic [ADC_BITS-1:0] mean_b,
   input  wire logic [ADC_BITS-1:0] spread_a,
   input  wire logic [ADC_BITS-1:0] spread_b,
   input  wire logic [DATA_W-1:0]   limit,
   output rsp_word_type             word
);

   logic [ADC_BITS-1:0] spread_max;
   logic                in_limit;
   rsp_word_type        word_ff;
   rsp_word_type        word_in;

   assign spread_max = (spread_a > spread_b) ? spread_a : spread_b;
   assign in_limit   = (32'(spread_max) <= 32'(limit));

   always_comb begin
      word_in.axis_out = tag.axis;
      if (tag.aborted) begin
         word_in.offset_a  = '0;
         word_in.offset_b  = '0;
         word_in.spread    = '0;
         word_in.offset_ok = 1'b0;
         word_in.aborted   = 1'b1;
      end else begin
         word_in.offset_a  = DATA_W'(mean_a);
         word_in.offset_b  = DATA_W'(mean_b);
         word_in.spread    = DATA_W'(spread_max);
         word_in.offset_ok = in_limit;
         word_in.aborted   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

`default_nettype wire

>>> sv/current_offset_calibrator.sv
// ----------------------------------------------------------------------------
// current_offset_calibrator
// Zero-current offset calibration for the phase-current channels of up to
// two motor axes.
// ----------------------------------------------------------------------------
// Accepts one request word per clock while ready is high. A start word for
// an axis either begins a capture (no response) or, when that axis's power
// outputs are enabled, is refused with an aborted response. Sample words
// are taken while the axis is capturing; the OFFSET_SAMPLES-th one yields a
// response carrying both mean codes, the larger min-to-max spread and the
// valid flag against spread_limit. Both channels run in their own lane; the
// mean is found by a reciprocal multiply and one correction step. A new
// response can follow every clock while the response side is ready. A stall
// on the response side fills the four pipeline stages before the request side
// sees ready low. The spread_limit register takes a write in any cycle and
// should only be changed while no response is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module current_offset_calibrator import coc_pkg::*; #(
   parameter int OFFSET_SAMPLES = 64,
   parameter int ADC_BITS       = 12,
   parameter int AXES           = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   coc_req_if.sink   req_ch,
   coc_rsp_if.source rsp_ch,
   coc_csr_if.sink   csr_ch
);

   localparam int AX_W  = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int CNT_W = $clog2(OFFSET_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OFFSET_SAMPLES);

   logic [DATA_W-1:0] limit_ff;

   logic [CNT_W-1:0] count_ff [AXES];
   logic             capturing_ff [AXES];
   logic [CNT_W-1:0] count_in;
   logic             capturing_in;

   logic             accept;
   logic             in_range;
   logic [AX_W-1:0]  idx;
   logic             is_start;
   logic             abort;
   logic             done;
   logic             emit;
   lane_cmd_type     cmd;
   pipe_en_type      en;

   logic    v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   tag_type tag1_ff, tag2_ff, tag3_ff;
   tag_type tag_in;
   logic    rdy1, rdy2, rdy3, out_free;

   logic [ADC_BITS-1:0] mean_a, mean_b, spread_a, spread_b;
   rsp_word_type        word;

   // register port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SPREAD_LIMIT_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         limit_ff <= csr_ch.data;
      end
   end

   // pipeline flow
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rdy3     = !v3_ff || out_free;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;

   assign req_ch.ready = rdy1;
   assign accept       = req_ch.valid && req_ch.ready;

   // capture control
   assign in_range = (32'(req_ch.axis) < AXES);
   assign idx      = AX_W'(req_ch.axis);
   assign is_start = (req_ch.func == FUNC_START);

   assign cmd.clr = accept && in_range && is_start && !req_ch.outputs_enabled;
   assign cmd.upd = accept && in_range && (req_ch.func == FUNC_SAMPLE) && capturing_ff[idx];
   assign abort   = accept && in_range && is_start && req_ch.outputs_enabled;
   assign done    = cmd.upd && ((count_ff[idx] + CNT_W'(1)) == CNT_LAST);
   assign emit    = done || abort;

   always_comb begin
      count_in     = count_ff[idx];
      capturing_in = capturing_ff[idx];
      if (cmd.clr) begin
         count_in     = '0;
         capturing_in = 1'b1;
      end else if (abort) begin
         capturing_in = 1'b0;
      end else if (cmd.upd) begin
         count_in     = count_ff[idx] + CNT_W'(1);
         capturing_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            count_ff[i]     <= '0;
            capturing_ff[i] <= 1'b0;
         end
      end else if (cmd.clr || cmd.upd || abort) begin
         count_ff[idx]     <= count_in;
         capturing_ff[idx] <= capturing_in;
      end
   end

   assign en.ld1 = emit && rdy1;
   assign en.ld2 = v1_ff && rdy2;
   assign en.ld3 = v2_ff && rdy3;

   assign tag_in.axis    = req_ch.axis;
   assign tag_in.aborted = abort;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= emit;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.ld1) begin
         tag1_ff <= tag_in;
      end
      if (en.ld2) begin
         tag2_ff <= tag1_ff;
      end
      if (en.ld3) begin
         tag3_ff <= tag2_ff;
      end
   end

   // channel lanes
   coc_lane #(
      .ADC_BITS       (ADC_BITS),
      .AXES           (AXES),
      .OFFSET_SAMPLES (OFFSET_SAMPLES),
      .AX_W           (AX_W)
   ) u_lane_a (
      .clock  (clock),
      .cmd    (cmd),
      .idx    (idx),
      .sample (ADC_BITS'(req_ch.sample_a)),
      .en     (en),
      .mean   (mean_a),
      .spread (spread_a)
   );

   coc_lane #(
      .ADC_BITS       (ADC_BITS),
      .AXES           (AXES),
      .OFFSET_SAMPLES (OFFSET_SAMPLES),
      .AX_W           (AX_W)
   ) u_lane_b (
      .clock  (clock),
      .cmd    (cmd),
      .idx    (idx),
      .sample (ADC_BITS'(req_ch.sample_b)),
      .en     (en),
      .mean   (mean_b),
      .spread (spread_b)
   );

   coc_merge #(
      .ADC_BITS (ADC_BITS)
   ) u_merge (
      .clock    (clock),
      .load     (v3_ff && out_free),
      .tag      (tag3_ff),
      .mean_a   (mean_a),
      .mean_b   (mean_b),
      .spread_a (spread_a),
      .spread_b (spread_b),
      .limit    (limit_ff),
      .word     (word)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.axis_out  = word.axis_out;
   assign rsp_ch.offset_a  = word.offset_a;
   assign rsp_ch.offset_b  = word.offset_b;
   assign rsp_ch.spread    = word.spread;
   assign rsp_ch.offset_ok = word.offset_ok;
   assign rsp_ch.aborted   = word.aborted;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      abort |=> v1_ff && tag1_ff.aborted)
      else $error("refused start did not enter the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      capturing_ff[0] |-> (count_ff[0] < CNT_LAST))
      else $error("sample count ran past the capture length");

   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.aborted |-> !rsp_ch.offset_ok && (rsp_ch.spread == '0))
      else $error("aborted word carries calibration data");
`endif

endmodule

`default_nettype wire
